// ===== hdl/spi_flash_page_program_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// SPI flash page program sequencer: assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPI_FLASH_PAGE_PROGRAM_SEQUENCER_DEFINES_SVH
`define SPI_FLASH_PAGE_PROGRAM_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define SPI_PP_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPI_PP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/spi_pp_pkg.sv =====
// ----------------------------------------------------------------------------
// spi_pp_pkg
// Constants, codes and result types of the SPI flash page program sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package spi_pp_pkg;

  // page size must be a power of two (page offset is the low address bits)
  localparam int PAGE_BYTES   = 256;
  localparam int ADDRESS_BITS = 24;

  localparam int ADDR_BYTES = (ADDRESS_BITS + 7) / 8;
  // write enable + program opcode + address bytes
  localparam int MAX_RES    = 2 + ADDR_BYTES;
  localparam int CNT_W      = $clog2(MAX_RES + 1);
  localparam int POFF_W     = $clog2(PAGE_BYTES);
  localparam int PBL_W      = POFF_W + 1;

  localparam int KIND_W      = 2;
  localparam int ADDR_IN_W   = 24;
  localparam int COUNT_W     = 24;
  localparam int BYTE_W      = 8;
  localparam int POLL_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 16;

  localparam int BUSY_BIT_POS = 0;

  typedef enum logic [KIND_W-1:0] {
    KIND_START  = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_STATUS = 2'd2,
    KIND_TICK   = 2'd3
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] REG_OPC_WREN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPC_PROG   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPC_RDSR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILLER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT = 3'd4;

  typedef struct packed {
    logic              byte_valid;
    logic [BYTE_W-1:0] spi_byte;
    logic              frame_end;
    logic              reply_expected;
    logic              write_done;
    logic              busy_timeout;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    res_t [MAX_RES-1:0]      ent;
  } res_list_t;

endpackage

`default_nettype wire

// ===== hdl/spi_pp_res_queue.sv =====
// ----------------------------------------------------------------------------
// spi_pp_res_queue
// Holds an input word's results, shifting one out per cycle while out_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "spi_flash_page_program_sequencer_defines.svh"

module spi_pp_res_queue
  import spi_pp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   load,
  input  wire res_list_t              list,
  output logic                        can_load,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // byte_valid, spi_byte[8], frame_end, reply_expected, write_done,
  // busy_timeout, zero pad
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast
);

  logic [CNT_W-1:0] cnt_r;
  res_t             ent_r [MAX_RES];
  logic             pop;

  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign can_load   = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_tready);
  assign out_tlast  = (cnt_r == CNT_W'(1));
  assign out_tdata  = {3'b000, ent_r[0].busy_timeout, ent_r[0].write_done,
                       ent_r[0].reply_expected, ent_r[0].frame_end,
                       ent_r[0].spi_byte, ent_r[0].byte_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= list.count;
    end else if (pop) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RES; i++) begin
        ent_r[i] <= list.ent[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        ent_r[i] <= ent_r[i+1];
      end
    end
  end

  `SPI_PP_ASSERT_IMPL(a_load_room, load,
    (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_tready), "load over pending words")
  `SPI_PP_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_r <= CNT_W'(MAX_RES), "word count overflow")
  `SPI_PP_ASSERT_NEXT(a_pop_dec, pop && !load,
    cnt_r == CNT_W'($past(cnt_r) - CNT_W'(1)), "pop did not retire one word")

endmodule

`default_nettype wire

// ===== hdl/spi_flash_page_program_sequencer.sv =====
// Latency: the first result word of an input word is on out_ the cycle after it is taken.
// Throughput: one SPI byte word per cycle while out_tready is high; a page start gives
// 2 + address bytes words (5 at 24-bit addressing), a mid-page data byte 1, a page end 3.
// The result queue takes the next input word while its last word is being taken.
// Reset: synchronous, active low; registers return to defaults, sequencer goes idle.
// ----------------------------------------------------------------------------
// spi_flash_page_program_sequencer
// Splits a flash write into page program frames and polls the busy status.
// ----------------------------------------------------------------------------
`default_nettype none
`include "spi_flash_page_program_sequencer_defines.svh"

module spi_flash_page_program_sequencer
  import spi_pp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // start_address[24], byte_count[24], data_byte[8], status_reply[8]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // kind[2]
  input  wire logic [KIND_W-1:0]      in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // byte_valid, spi_byte[8], frame_end, reply_expected, write_done,
  // busy_timeout, zero pad
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    P_IDLE,
    P_DATA,
    P_REPLY,
    P_TICK_BUSY,
    P_TICK_READY
  } phase_t;

  phase_t                   phase_r, phase_nxt;
  logic [ADDRESS_BITS-1:0]  addr_r, addr_nxt;
  logic [COUNT_W-1:0]       rem_r, rem_nxt;
  logic [PBL_W-1:0]         pbl_r, pbl_nxt;
  logic [POLL_W-1:0]        polls_r, polls_nxt;
  logic                     tmo_r, tmo_nxt;

  logic [BYTE_W-1:0]        opc_wren_r, opc_prog_r, opc_rdsr_r, filler_r;
  logic [POLL_W-1:0]        poll_limit_r;

  kind_t                    kind;
  logic [ADDR_IN_W-1:0]     in_addr;
  logic [COUNT_W-1:0]       in_count;
  logic [BYTE_W-1:0]        in_data;
  logic [BYTE_W-1:0]        in_status;
  logic                     in_fire;
  logic                     cfg_fire;
  logic                     q_can_load;
  res_list_t                list;

  assign kind      = kind_t'(in_tuser);
  assign in_addr   = in_tdata[23:0];
  assign in_count  = in_tdata[47:24];
  assign in_data   = in_tdata[55:48];
  assign in_status = in_tdata[63:56];
  assign in_tready = q_can_load;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  function automatic res_t mk(input logic bv, input logic [BYTE_W-1:0] b,
                              input logic fe, input logic re,
                              input logic dn, input logic to);
    res_t r;
    r.byte_valid     = bv;
    r.spi_byte       = b;
    r.frame_end      = fe;
    r.reply_expected = re;
    r.write_done     = dn;
    r.busy_timeout   = to;
    return r;
  endfunction

  // bytes of this page: the smaller of what is left and the room to the boundary
  function automatic logic [PBL_W-1:0] page_len(input logic [ADDRESS_BITS-1:0] a,
                                                input logic [COUNT_W-1:0] rem);
    logic [PBL_W-1:0] room;
    room = PBL_W'(PAGE_BYTES) - {1'b0, a[POFF_W-1:0]};
    if (rem < COUNT_W'(room)) begin
      return PBL_W'(rem);
    end
    return room;
  endfunction

  // write enable frame, then program opcode and address bytes, MSB first
  function automatic res_list_t page_start(input logic [ADDRESS_BITS-1:0] a,
                                           input logic [BYTE_W-1:0] we,
                                           input logic [BYTE_W-1:0] pp);
    res_list_t l;
    logic [31:0] a32;
    a32 = 32'(a);
    l.count  = CNT_W'(MAX_RES);
    l.ent[0] = mk(1'b1, we, 1'b1, 1'b0, 1'b0, 1'b0);
    l.ent[1] = mk(1'b1, pp, 1'b0, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < ADDR_BYTES; i++) begin
      l.ent[2+i] = mk(1'b1, a32[8*(ADDR_BYTES-1-i) +: 8], 1'b0, 1'b0, 1'b0, 1'b0);
    end
    return l;
  endfunction

  always_comb begin
    logic                    end_pg;
    logic [POLL_W-1:0]       polls_dec;
    logic [ADDRESS_BITS-1:0] ld_addr;
    phase_nxt = phase_r;
    addr_nxt  = addr_r;
    rem_nxt   = rem_r;
    pbl_nxt   = pbl_r;
    polls_nxt = polls_r;
    tmo_nxt   = tmo_r;
    list      = '0;
    end_pg    = (pbl_r <= PBL_W'(1));
    polls_dec = (polls_r != '0) ? polls_r - POLL_W'(1) : polls_r;
    ld_addr   = ADDRESS_BITS'(32'(in_addr));
    unique case (kind)
      KIND_START: begin
        if (phase_r == P_IDLE) begin
          addr_nxt = ld_addr;
          rem_nxt  = in_count;
          tmo_nxt  = 1'b0;
          if (in_count == '0) begin
            list.count  = CNT_W'(1);
            list.ent[0] = mk(1'b0, '0, 1'b0, 1'b0, 1'b1, 1'b0);
          end else begin
            list      = page_start(ld_addr, opc_wren_r, opc_prog_r);
            pbl_nxt   = page_len(ld_addr, in_count);
            phase_nxt = P_DATA;
          end
        end
      end
      KIND_DATA: begin
        if (phase_r == P_DATA) begin
          list.count  = CNT_W'(1);
          list.ent[0] = mk(1'b1, in_data, end_pg, 1'b0, 1'b0, 1'b0);
          if (pbl_r != '0) pbl_nxt = pbl_r - PBL_W'(1);
          if (rem_r != '0) rem_nxt = rem_r - COUNT_W'(1);
          addr_nxt = addr_r + ADDRESS_BITS'(1);
          if (end_pg) begin
            pbl_nxt     = '0;
            polls_nxt   = (poll_limit_r != '0) ? poll_limit_r : POLL_W'(1);
            list.count  = CNT_W'(3);
            list.ent[1] = mk(1'b1, opc_rdsr_r, 1'b0, 1'b0, 1'b0, 1'b0);
            list.ent[2] = mk(1'b1, filler_r, 1'b1, 1'b1, 1'b0, 1'b0);
            phase_nxt   = P_REPLY;
          end
        end
      end
      KIND_STATUS: begin
        if (phase_r == P_REPLY) begin
          phase_nxt = in_status[BUSY_BIT_POS] ? P_TICK_BUSY : P_TICK_READY;
        end
      end
      default: begin
        if (phase_r == P_TICK_BUSY || phase_r == P_TICK_READY) begin
          polls_nxt = polls_dec;
          if (phase_r == P_TICK_READY || polls_dec == '0) begin
            if (phase_r == P_TICK_BUSY) tmo_nxt = 1'b1;
            if (rem_r == '0) begin
              list.count  = CNT_W'(1);
              list.ent[0] = mk(1'b0, '0, 1'b0, 1'b0, 1'b1, tmo_nxt);
              phase_nxt   = P_IDLE;
            end else begin
              list      = page_start(addr_r, opc_wren_r, opc_prog_r);
              pbl_nxt   = page_len(addr_r, rem_r);
              phase_nxt = P_DATA;
            end
          end else begin
            list.count  = CNT_W'(2);
            list.ent[0] = mk(1'b1, opc_rdsr_r, 1'b0, 1'b0, 1'b0, 1'b0);
            list.ent[1] = mk(1'b1, filler_r, 1'b1, 1'b1, 1'b0, 1'b0);
            phase_nxt   = P_REPLY;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= P_IDLE;
      addr_r       <= '0;
      rem_r        <= '0;
      pbl_r        <= '0;
      polls_r      <= '0;
      tmo_r        <= 1'b0;
      opc_wren_r   <= 8'h06;
      opc_prog_r   <= 8'h02;
      opc_rdsr_r   <= 8'h05;
      filler_r     <= 8'hFF;
      poll_limit_r <= 16'd10;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
        addr_r  <= addr_nxt;
        rem_r   <= rem_nxt;
        pbl_r   <= pbl_nxt;
        polls_r <= polls_nxt;
        tmo_r   <= tmo_nxt;
      end
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_OPC_WREN:   opc_wren_r   <= cfg_data[7:0];
          REG_OPC_PROG:   opc_prog_r   <= cfg_data[7:0];
          REG_OPC_RDSR:   opc_rdsr_r   <= cfg_data[7:0];
          REG_FILLER:     filler_r     <= cfg_data[7:0];
          REG_POLL_LIMIT: poll_limit_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  spi_pp_res_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_fire),
    .list       (list),
    .can_load   (q_can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `SPI_PP_ASSERT_IMPL(a_data_counts, phase_r == P_DATA,
    (pbl_r != '0) && (COUNT_W'(pbl_r) <= rem_r), "page count out of step with remaining")
  `SPI_PP_ASSERT_IMPL(a_poll_page_clear,
    phase_r == P_REPLY || phase_r == P_TICK_BUSY || phase_r == P_TICK_READY,
    pbl_r == '0, "page count left over while polling")
  `SPI_PP_ASSERT_NEXT(a_start_ignored,
    in_fire && kind == KIND_START && phase_r != P_IDLE,
    phase_r == $past(phase_r), "start outside idle changed phase")

endmodule

`default_nettype wire
